[sv/wola_pkg.sv]
// ----------------------------------------------------------------------------
// wola_pkg
// Shared constants, codes and types of the windowed overlap-add block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package wola_pkg;

    // Storage depth and sample width
    localparam int MAX_FRAME   = 1024;
    localparam int SAMPLE_BITS = 16;

    // Derived widths
    localparam int ADDR_W = $clog2(MAX_FRAME);
    localparam int LEN_W  = ADDR_W + 1;

    // Fixed field widths
    localparam int LEN_CFG_W  = 11;
    localparam int COEF_IDX_W = 10;
    localparam int COEF_W     = 16;
    localparam int GAIN_W     = 16;
    localparam int ACC_W      = 32;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int FRAC_BITS  = 15;

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // Register reset values
    localparam logic [LEN_CFG_W-1:0]  FRAME_LENGTH_RESET = 11'd1024;
    localparam logic [LEN_CFG_W-1:0]  HOP_LENGTH_RESET   = 11'd512;
    localparam logic [GAIN_W-1:0]     OUTPUT_GAIN_RESET  = 16'd32768;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HOP_LENGTH   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_GAIN  = 2'd2;

    // Item modes
    localparam logic MODE_COEF   = 1'b0;
    localparam logic MODE_SAMPLE = 1'b1;

    typedef enum logic {
        FS_RUN,
        FS_NORM
    } t_front_state;

    typedef enum logic [1:0] {
        BS_CLEAR,
        BS_IDLE,
        BS_MUL,
        BS_ADD
    } t_back_state;

    // Classified item as queued for the back end
    typedef struct packed {
        logic                   mode;
        logic [ADDR_W-1:0]      idx;      // coefficient index or frame position
        logic [ADDR_W-1:0]      addr;     // accumulator entry
        logic [COEF_W-1:0]      coef;
        logic [SAMPLE_BITS-1:0] sample;
        logic                   emit;
        logic                   hop_end;
    } t_cmd;

    // Effective framing seen by the front end
    typedef struct packed {
        logic             wr;
        logic [LEN_W-1:0] len;
        logic [LEN_W-1:0] hop;
    } t_cfg;

endpackage

`default_nettype wire

[sv/wola_front.sv]
// ----------------------------------------------------------------------------
// wola_front
// Accepts items, tracks frame position and ring base, queues commands.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wola_front (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  wola_pkg::t_cfg                  i_cfg,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic                            i_mode,
    input  logic [wola_pkg::COEF_IDX_W-1:0] i_coef_index,
    input  logic [wola_pkg::COEF_W-1:0]     i_coef_value,
    input  logic signed [wola_pkg::SAMPLE_BITS-1:0] i_sample,
    input  logic                            i_back_busy,
    input  logic                            i_q_full,
    output logic                            o_q_push,
    output wola_pkg::t_cmd                  o_q_cmd
);
    import wola_pkg::*;

    localparam int STEP_W = $clog2(ADDR_W + 1);

    t_front_state      r_state, n_state;
    logic [ADDR_W-1:0] r_pos, n_pos;
    logic [ADDR_W-1:0] r_base, n_base;
    logic [ADDR_W-1:0] r_hp, n_hp;      // position as left by the last sample
    logic [ADDR_W-1:0] r_hb, n_hb;      // ring base as left by the last sample
    logic [ADDR_W-1:0] r_dp, n_dp;
    logic [ADDR_W-1:0] r_db, n_db;
    logic [ADDR_W-1:0] r_rp, n_rp;
    logic [ADDR_W-1:0] r_rb, n_rb;
    logic [STEP_W-1:0] r_step, n_step;

    logic              w_accept;
    logic [LEN_W-1:0]  w_pos_ext;
    logic [ADDR_W-1:0] w_addr;
    logic [ADDR_W-1:0] w_base_wrap;
    logic              w_last;
    logic [31:0]       w_idx_ext;
    logic              w_idx_ok;

    // One restoring step of a remainder by len
    function automatic logic [ADDR_W-1:0] f_mod_step(
        input logic [ADDR_W-1:0] rem,
        input logic              bit_in,
        input logic [LEN_W-1:0]  len
    );
        logic [LEN_W-1:0] t;
        t = {rem, bit_in};
        if (t >= len) begin
            t = t - len;
        end
        return t[ADDR_W-1:0];
    endfunction

    // Wrap a sum known to be below twice len
    function automatic logic [ADDR_W-1:0] f_wrap(
        input logic [LEN_W-1:0] sum,
        input logic [LEN_W-1:0] len
    );
        logic [LEN_W-1:0] t;
        t = sum;
        if (t >= len) begin
            t = t - len;
        end
        return t[ADDR_W-1:0];
    endfunction

    assign o_in_stall  = (r_state != FS_RUN) || i_q_full || i_back_busy;
    assign w_accept    = i_in_valid && !o_in_stall;
    assign w_pos_ext   = LEN_W'(r_pos);
    assign w_addr      = f_wrap(w_pos_ext + LEN_W'(r_base), i_cfg.len);
    assign w_base_wrap = f_wrap(LEN_W'(r_base) + i_cfg.hop, i_cfg.len);
    assign w_last      = (w_pos_ext + LEN_W'(1)) >= i_cfg.len;
    assign w_idx_ext   = 32'(i_coef_index);
    assign w_idx_ok    = w_idx_ext < 32'(MAX_FRAME);

    always_comb begin
        o_q_cmd.mode    = i_mode;
        o_q_cmd.idx     = (i_mode == MODE_SAMPLE) ? r_pos : w_idx_ext[ADDR_W-1:0];
        o_q_cmd.addr    = w_addr;
        o_q_cmd.coef    = i_coef_value;
        o_q_cmd.sample  = i_sample;
        o_q_cmd.emit    = w_pos_ext < i_cfg.hop;
        o_q_cmd.hop_end = w_pos_ext == (i_cfg.hop - LEN_W'(1));
    end

    always_comb begin
        n_state  = r_state;
        n_pos    = r_pos;
        n_base   = r_base;
        n_hp     = r_hp;
        n_hb     = r_hb;
        n_dp     = r_dp;
        n_db     = r_db;
        n_rp     = r_rp;
        n_rb     = r_rb;
        n_step   = r_step;
        o_q_push = 1'b0;
        case (r_state)
            FS_RUN: begin
                if (w_accept) begin
                    if (i_mode == MODE_SAMPLE) begin
                        o_q_push = 1'b1;
                        if (w_last) begin
                            n_pos  = '0;
                            n_base = w_base_wrap;
                        end else begin
                            n_pos = r_pos + ADDR_W'(1);
                        end
                        n_hp = n_pos;
                        n_hb = n_base;
                    end else begin
                        o_q_push = w_idx_ok;
                    end
                end
            end
            FS_NORM: begin
                // rewrap position and base one dividend bit at a time
                n_rp   = f_mod_step(r_rp, r_dp[ADDR_W-1], i_cfg.len);
                n_rb   = f_mod_step(r_rb, r_db[ADDR_W-1], i_cfg.len);
                n_dp   = r_dp << 1;
                n_db   = r_db << 1;
                n_step = r_step + STEP_W'(1);
                if (r_step == STEP_W'(ADDR_W - 1)) begin
                    n_state = FS_RUN;
                    n_pos   = n_rp;
                    n_base  = n_rb;
                end
            end
            default: begin
                n_state = FS_RUN;
            end
        endcase
        // restart from the held values on any register write
        if (i_cfg.wr) begin
            n_state = FS_NORM;
            n_step  = '0;
            n_dp    = n_hp;
            n_db    = n_hb;
            n_rp    = '0;
            n_rb    = '0;
            n_pos   = r_pos;
            n_base  = r_base;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= FS_RUN;
            r_pos   <= '0;
            r_base  <= '0;
            r_hp    <= '0;
            r_hb    <= '0;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_pos   <= n_pos;
            r_base  <= n_base;
            r_hp    <= n_hp;
            r_hb    <= n_hb;
            r_step  <= n_step;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dp <= n_dp;
        r_db <= n_db;
        r_rp <= n_rp;
        r_rb <= n_rb;
    end

endmodule

`default_nettype wire

[sv/wola_queue.sv]
// ----------------------------------------------------------------------------
// wola_queue
// Short command queue between the front and back ends.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wola_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  wola_pkg::t_cmd i_cmd,
    output logic           o_full,
    input  logic           i_pop,
    output wola_pkg::t_cmd o_cmd,
    output logic           o_empty
);
    import wola_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_cmd             r_slot [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr;
    logic [PTR_W-1:0] r_rd, n_rd;
    logic [CNT_W-1:0] r_count, n_count;

    function automatic logic [PTR_W-1:0] f_next(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign o_full  = r_count == CNT_W'(QUEUE_DEPTH);
    assign o_empty = r_count == '0;
    assign o_cmd   = r_slot[r_rd];

    always_comb begin
        n_wr    = i_push ? f_next(r_wr) : r_wr;
        n_rd    = i_pop ? f_next(r_rd) : r_rd;
        n_count = r_count;
        case ({i_push, i_pop})
            2'b10:   n_count = r_count + CNT_W'(1);
            2'b01:   n_count = r_count - CNT_W'(1);
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr] <= i_cmd;
        end
    end

endmodule

`default_nettype wire

[sv/wola_back.sv]
// ----------------------------------------------------------------------------
// wola_back
// Window and accumulator stores, multiply-accumulate, gain and output stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wola_back (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_empty,
    input  wola_pkg::t_cmd                   i_cmd,
    output logic                             o_pop,
    input  logic [wola_pkg::GAIN_W-1:0]      i_gain,
    output logic                             o_clearing,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic signed [wola_pkg::SAMPLE_BITS-1:0] o_out_sample,
    output logic                             o_hop_end
);
    import wola_pkg::*;

    localparam int PROD_W  = SAMPLE_BITS + COEF_W + 1;
    localparam int SUM_W   = ACC_W + 2;
    localparam int GPROD_W = ACC_W + GAIN_W + 1;
    localparam int ROUND_HALF = 1 << (FRAC_BITS - 1);

    t_back_state r_state, n_state;
    logic [ADDR_W-1:0] r_clr;

    logic [COEF_W-1:0]       r_win_mem [MAX_FRAME];
    logic signed [ACC_W-1:0] r_acc_mem [MAX_FRAME];

    logic [COEF_W-1:0]            r_win_rd;
    logic signed [ACC_W-1:0]      r_acc_rd;
    logic signed [SAMPLE_BITS-1:0] r_sample;
    logic [ADDR_W-1:0]            r_addr;
    logic                         r_emit;
    logic                         r_end;
    logic signed [PROD_W-1:0]     r_prod;

    logic                         r_g1_valid;
    logic signed [ACC_W-1:0]      r_g1_acc;
    logic                         r_g1_end;
    logic                         r_g2_valid;
    logic signed [GPROD_W-1:0]    r_g2_prod;
    logic                         r_g2_end;
    logic                         r_o_valid;
    logic signed [SAMPLE_BITS-1:0] r_o_sample;
    logic                         r_o_end;

    logic                    w_win_we;
    logic                    w_rd_en;
    logic                    w_acc_we;
    logic [ADDR_W-1:0]       w_acc_wa;
    logic signed [ACC_W-1:0] w_acc_wd;
    logic                    w_cap;
    logic                    w_g1_load;

    logic signed [COEF_W:0]     w_coef_s;
    logic signed [PROD_W-1:0]   w_prod;
    logic signed [PROD_W:0]     w_prod_rnd;
    logic signed [PROD_W:0]     w_prod_sh;
    logic signed [SUM_W-1:0]    w_sum;
    logic [SUM_W-ACC_W:0]       w_sum_top;
    logic signed [ACC_W-1:0]    w_acc_sat;
    logic signed [GAIN_W:0]     w_gain_s;
    logic signed [GPROD_W:0]    w_g_rnd;
    logic signed [GPROD_W:0]    w_g_sh;
    logic [GPROD_W-SAMPLE_BITS+1:0] w_g_top;
    logic signed [SAMPLE_BITS-1:0]  w_out_sat;

    logic w_out_ld, w_g2_free, w_g1_move, w_g1_free;

    // Sample times coefficient, round half up, accumulate with saturation
    assign w_coef_s   = $signed({1'b0, r_win_rd});
    assign w_prod     = PROD_W'(r_sample) * PROD_W'(w_coef_s);
    assign w_prod_rnd = (PROD_W + 1)'(r_prod) + (PROD_W + 1)'(ROUND_HALF);
    assign w_prod_sh  = w_prod_rnd >>> FRAC_BITS;
    assign w_sum      = SUM_W'(r_acc_rd) + SUM_W'(w_prod_sh);
    assign w_sum_top  = w_sum[SUM_W-1:ACC_W-1];
    assign w_acc_sat  = ((&w_sum_top) || !(|w_sum_top)) ? w_sum[ACC_W-1:0] :
                        (w_sum[SUM_W-1] ? {1'b1, {(ACC_W-1){1'b0}}}
                                        : {1'b0, {(ACC_W-1){1'b1}}});

    // Gain product, round half up, saturate to the sample range
    assign w_gain_s  = $signed({1'b0, i_gain});
    assign w_g_rnd   = (GPROD_W + 1)'(r_g2_prod) + (GPROD_W + 1)'(ROUND_HALF);
    assign w_g_sh    = w_g_rnd >>> FRAC_BITS;
    assign w_g_top   = w_g_sh[GPROD_W:SAMPLE_BITS-1];
    assign w_out_sat = ((&w_g_top) || !(|w_g_top)) ? w_g_sh[SAMPLE_BITS-1:0] :
                       (w_g_sh[GPROD_W] ? {1'b1, {(SAMPLE_BITS-1){1'b0}}}
                                        : {1'b0, {(SAMPLE_BITS-1){1'b1}}});

    // Elastic gain pipeline
    assign w_out_ld  = !r_o_valid || !i_out_stall;
    assign w_g2_free = !r_g2_valid || w_out_ld;
    assign w_g1_move = r_g1_valid && w_g2_free;
    assign w_g1_free = !r_g1_valid || w_g2_free;

    assign o_clearing   = r_state == BS_CLEAR;
    assign o_out_valid  = r_o_valid;
    assign o_out_sample = r_o_sample;
    assign o_hop_end    = r_o_end;

    always_comb begin
        n_state   = r_state;
        o_pop     = 1'b0;
        w_win_we  = 1'b0;
        w_rd_en   = 1'b0;
        w_cap     = 1'b0;
        w_acc_we  = 1'b0;
        w_acc_wa  = r_addr;
        w_acc_wd  = '0;
        w_g1_load = 1'b0;
        case (r_state)
            BS_CLEAR: begin
                w_acc_we = 1'b1;
                w_acc_wa = r_clr;
                if (r_clr == ADDR_W'(MAX_FRAME - 1)) begin
                    n_state = BS_IDLE;
                end
            end
            BS_IDLE: begin
                if (!i_empty) begin
                    o_pop = 1'b1;
                    if (i_cmd.mode == MODE_COEF) begin
                        w_win_we = 1'b1;
                    end else begin
                        w_rd_en = 1'b1;
                        w_cap   = 1'b1;
                        n_state = BS_MUL;
                    end
                end
            end
            BS_MUL: begin
                n_state = BS_ADD;
            end
            BS_ADD: begin
                // hold while an emitted value has no room in the gain pipeline
                if (!r_emit || w_g1_free) begin
                    w_acc_we  = 1'b1;
                    w_acc_wd  = r_emit ? '0 : w_acc_sat;
                    w_g1_load = r_emit;
                    n_state   = BS_IDLE;
                end
            end
            default: begin
                n_state = BS_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= BS_CLEAR;
            r_clr      <= '0;
            r_g1_valid <= 1'b0;
            r_g2_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == BS_CLEAR) begin
                r_clr <= r_clr + ADDR_W'(1);
            end
            if (w_g1_free) begin
                r_g1_valid <= w_g1_load;
            end
            if (w_g2_free) begin
                r_g2_valid <= r_g1_valid;
            end
            if (w_out_ld) begin
                r_o_valid <= r_g2_valid;
            end
        end
    end

    // Stores
    always_ff @(posedge i_clk) begin
        if (w_win_we) begin
            r_win_mem[i_cmd.idx] <= i_cmd.coef;
        end
        if (w_rd_en) begin
            r_win_rd <= r_win_mem[i_cmd.idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc_we) begin
            r_acc_mem[w_acc_wa] <= w_acc_wd;
        end
        if (w_rd_en) begin
            r_acc_rd <= r_acc_mem[i_cmd.addr];
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (w_cap) begin
            r_sample <= $signed(i_cmd.sample);
            r_addr   <= i_cmd.addr;
            r_emit   <= i_cmd.emit;
            r_end    <= i_cmd.hop_end;
        end
        r_prod <= w_prod;
        if (w_g1_load) begin
            r_g1_acc <= w_acc_sat;
            r_g1_end <= r_end;
        end
        if (w_g1_move) begin
            r_g2_prod <= GPROD_W'(r_g1_acc) * GPROD_W'(w_gain_s);
            r_g2_end  <= r_g1_end;
        end
        if (w_out_ld && r_g2_valid) begin
            r_o_sample <= w_out_sat;
            r_o_end    <= r_g2_end;
        end
    end

endmodule

`default_nettype wire

[sv/windowed_overlap_add.sv]
// Path: queue, store reads, product, accumulate-and-write, g1 and g2 gain, output register.
// Flow: the back end takes no new data sample until its read, multiply, accumulate-and-write
//   sequence on the single accumulator write port is done. A register write rewraps position
//   and base one dividend bit at a time (ADDR_W bits).
// Reset: every accumulator entry (MAX_FRAME of them) is zeroed with input stalled.
// ----------------------------------------------------------------------------
// windowed_overlap_add
// Weighted overlap-add synthesis: window each frame, add into a circular
// accumulator, emit one hop per frame scaled by a gain and saturated.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module windowed_overlap_add (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // register write channel
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [wola_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [wola_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    // input item channel
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic                             i_mode,
    input  logic [wola_pkg::COEF_IDX_W-1:0]  i_coef_index,
    input  logic [wola_pkg::COEF_W-1:0]      i_coef_value,
    input  logic signed [wola_pkg::SAMPLE_BITS-1:0] i_sample,
    // result channel
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic signed [wola_pkg::SAMPLE_BITS-1:0] o_out_sample,
    output logic                             o_hop_end
);
    import wola_pkg::*;

    logic [LEN_W-1:0]     r_frame_len;   // effective length, clamped on write
    logic [LEN_CFG_W-1:0] r_hop;
    logic [GAIN_W-1:0]    r_gain;

    logic   w_cfg_wr;
    t_cfg   w_cfg;
    logic   w_q_push;
    logic   w_q_full;
    logic   w_q_empty;
    logic   w_q_pop;
    t_cmd   w_push_cmd;
    t_cmd   w_head_cmd;
    logic   w_clearing;

    // Clamp frame length: zero acts as one, anything above the store depth saturates
    function automatic logic [LEN_W-1:0] f_eff_len(input logic [LEN_CFG_W-1:0] v);
        logic [LEN_W-1:0] r;
        if (v == '0) begin
            r = LEN_W'(1);
        end else if (32'(v) > 32'(MAX_FRAME)) begin
            r = LEN_W'(MAX_FRAME);
        end else begin
            r = LEN_W'(v);
        end
        return r;
    endfunction

    // Clamp hop: zero acts as one, anything above the frame length saturates
    function automatic logic [LEN_W-1:0] f_eff_hop(
        input logic [LEN_CFG_W-1:0] h,
        input logic [LEN_W-1:0]     len
    );
        logic [LEN_W-1:0] r;
        if (h == '0) begin
            r = LEN_W'(1);
        end else if (32'(h) > 32'(len)) begin
            r = len;
        end else begin
            r = LEN_W'(h);
        end
        return r;
    endfunction

    // Register port never back-pressures; user keeps writes only while idle, unenforced.
    assign o_cfg_ready = 1'b1;
    assign w_cfg_wr    = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_len <= f_eff_len(FRAME_LENGTH_RESET);
            r_hop       <= HOP_LENGTH_RESET;
            r_gain      <= OUTPUT_GAIN_RESET;
        end else if (w_cfg_wr) begin
            case (i_cfg_index)
                CFG_FRAME_LENGTH: r_frame_len <= f_eff_len(i_cfg_data[LEN_CFG_W-1:0]);
                CFG_HOP_LENGTH:   r_hop       <= i_cfg_data[LEN_CFG_W-1:0];
                CFG_OUTPUT_GAIN:  r_gain      <= i_cfg_data[GAIN_W-1:0];
                default: begin
                    // unused index: drop the transfer
                end
            endcase
        end
    end

    // Framing as the front end sees it; any write makes the front rewrap
    // its frame position and ring base against the new length.
    always_comb begin
        w_cfg.wr  = w_cfg_wr;
        w_cfg.len = r_frame_len;
        w_cfg.hop = f_eff_hop(r_hop, r_frame_len);
    end

    // Front end: accept, classify, compute the accumulator entry and
    // whether the position falls inside the emitted hop.
    wola_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (w_cfg),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_mode       (i_mode),
        .i_coef_index (i_coef_index),
        .i_coef_value (i_coef_value),
        .i_sample     (i_sample),
        .i_back_busy  (w_clearing),
        .i_q_full     (w_q_full),
        .o_q_push     (w_q_push),
        .o_q_cmd      (w_push_cmd)
    );

    // Queue: lets the front keep taking items while the back works.
    wola_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_cmd   (w_push_cmd),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_cmd   (w_head_cmd),
        .o_empty (w_q_empty)
    );

    // Back end: stores, multiply-accumulate, gain and the output register.
    wola_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_empty      (w_q_empty),
        .i_cmd        (w_head_cmd),
        .o_pop        (w_q_pop),
        .i_gain       (r_gain),
        .o_clearing   (w_clearing),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_sample (o_out_sample),
        .o_hop_end    (o_hop_end)
    );

`ifndef SYNTHESIS
    // No result may appear while the accumulator store is still being zeroed.
    a_no_out_while_clearing: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        w_clearing |-> !o_out_valid
    ) else $error("result presented during accumulator clear");

    // A register write must hold off items while position and base rewrap.
    a_stall_after_cfg: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        w_cfg_wr |=> o_in_stall
    ) else $error("input not stalled after register write");

    // The front must never push into a full queue.
    a_no_push_when_full: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        w_q_full |-> !w_q_push
    ) else $error("command pushed into full queue");
`endif

endmodule

`default_nettype wire

[sim/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the windowed overlap-add block. A directed table
// of coefficient loads, register writes and samples comes first, then
// randomized framing phases. Every result is checked in order against a hand-written
// value or a behavioral model of the windowed accumulate, emit and clear sequence.
// ----------------------------------------------------------------------------

module tb_top;
    import wola_pkg::*;

    // Register index that no register answers to
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    localparam int RANDOM_ITEMS  = 750;
    localparam int QUIET_FROM    = 640;   // no idling on either side past this item
    localparam int SETTLE_CYCLES = 32;    // pipeline drain before a register write

    localparam longint ACC_MAX = 64'sd2147483647;
    localparam longint ACC_MIN = -64'sd2147483648;
    localparam longint OUT_MAX = 64'sd32767;
    localparam longint OUT_MIN = -64'sd32768;

    typedef enum logic {
        ROW_ITEM,
        ROW_CFG
    } t_row_kind;

    // One line of the directed table: either a register write or an item
    typedef struct packed {
        t_row_kind              kind;
        logic [CFG_IDX_W-1:0]   cfg_index;
        logic [CFG_DATA_W-1:0]  cfg_data;
        logic                   mode;
        logic [COEF_IDX_W-1:0]  coef_index;
        logic [COEF_W-1:0]      coef_value;
        logic [SAMPLE_BITS-1:0] sample;
        logic                   typed;      // expected result written out by hand
        logic [SAMPLE_BITS-1:0] want_sample;
        logic                   want_hop_end;
    } t_stim_row;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] out_sample;
        logic                   hop_end;
    } t_hop_sample;

    // ------------------------------------------------------------------------
    // DUT ports
    // ------------------------------------------------------------------------
    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_cfg_valid;
    logic                          o_cfg_ready;
    logic [CFG_IDX_W-1:0]          i_cfg_index;
    logic [CFG_DATA_W-1:0]         i_cfg_data;
    logic                          i_in_valid;
    logic                          o_in_stall;
    logic                          i_mode;
    logic [COEF_IDX_W-1:0]         i_coef_index;
    logic [COEF_W-1:0]             i_coef_value;
    logic signed [SAMPLE_BITS-1:0] i_sample;
    logic                          o_out_valid;
    logic                          i_out_stall;
    logic signed [SAMPLE_BITS-1:0] o_out_sample;
    logic                          o_hop_end;

    windowed_overlap_add u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_mode       (i_mode),
        .i_coef_index (i_coef_index),
        .i_coef_value (i_coef_value),
        .i_sample     (i_sample),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_sample (o_out_sample),
        .o_hop_end    (o_hop_end)
    );

    // ------------------------------------------------------------------------
    // Model state: window table, accumulator ring, framing and registers
    // ------------------------------------------------------------------------
    logic [COEF_W-1:0]    window_coef [MAX_FRAME];
    logic [ACC_W-1:0]     overlap_acc [MAX_FRAME];
    bit                   coef_loaded [MAX_FRAME];   // never read an unloaded entry
    logic [LEN_CFG_W-1:0] frame_len_reg;
    logic [LEN_CFG_W-1:0] hop_len_reg;
    logic [GAIN_W-1:0]    gain_reg;
    int unsigned          frame_pos;
    int unsigned          ring_base;

    t_hop_sample samples_due [$];    // emitted samples still on their way out
    int          error_count = 0;
    bit          idle_enable = 1'b1;
    int          random_items = 0;

    // ------------------------------------------------------------------------
    // Model arithmetic
    // ------------------------------------------------------------------------
    function automatic int unsigned effective_len(input logic [LEN_CFG_W-1:0] raw);
        int unsigned len;
        len = raw;
        if (len == 0) len = 1;
        if (len > MAX_FRAME) len = MAX_FRAME;
        return len;
    endfunction

    // Q.30 to Q.15 with round half toward plus infinity; >>> floors signed values
    function automatic longint round_q15(input longint v);
        return (v + 64'sd16384) >>> FRAC_BITS;
    endfunction

    function automatic longint clamp(input longint v, input longint lo, input longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic logic [COEF_W-1:0] random_coef();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 5) return '0;
        if (r < 10) return '1;
        return COEF_W'($urandom);
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] random_sample();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 6) return 16'h7FFF;
        if (r < 12) return 16'h8000;
        return SAMPLE_BITS'($urandom);
    endfunction

    // Advance the model by one transferred item; emit is set when a result is due
    task automatic overlap_add_step(
        input  logic                   mode,
        input  logic [COEF_IDX_W-1:0]  cidx,
        input  logic [COEF_W-1:0]      cval,
        input  logic [SAMPLE_BITS-1:0] smp,
        output bit                     emit,
        output logic [SAMPLE_BITS-1:0] y,
        output logic                   he
    );
        int unsigned len, hop, pos, addr;
        longint      acc, scaled;
        emit = 1'b0;
        y    = '0;
        he   = 1'b0;
        if (mode == MODE_COEF) begin
            window_coef[cidx] = cval;
        end else begin
            len = effective_len(frame_len_reg);
            hop = hop_len_reg;
            if (hop == 0) hop = 1;
            if (hop > len) hop = len;
            // A register change mid-frame rewraps position and base
            pos       = frame_pos % len;
            ring_base = ring_base % len;
            addr      = (ring_base + pos) % len;

            acc = longint'($signed(overlap_acc[addr]))
                + round_q15(longint'($signed(smp)) * longint'(window_coef[pos]));
            acc = clamp(acc, ACC_MIN, ACC_MAX);
            overlap_acc[addr] = acc[ACC_W-1:0];

            if (pos < hop) begin
                scaled = clamp(round_q15(acc * longint'(gain_reg)), OUT_MIN, OUT_MAX);
                y      = scaled[SAMPLE_BITS-1:0];
                he     = (pos == hop - 1);
                emit   = 1'b1;
                overlap_acc[addr] = '0;
            end

            if (pos + 1 >= len) begin
                frame_pos = 0;
                ring_base = (ring_base + hop) % len;
            end else begin
                frame_pos = pos + 1;
            end
        end
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("[%0t] mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
        error_count++;
    endtask

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------

    // Drain everything in flight, then transfer one register write.
    // Items that emit nothing may still be inside, so wait out the pipeline too.
    task automatic write_register(input logic [CFG_IDX_W-1:0]  index,
                                  input logic [CFG_DATA_W-1:0] data);
        i_in_valid <= 1'b0;
        while (samples_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (index)
            CFG_FRAME_LENGTH: frame_len_reg = data[LEN_CFG_W-1:0];
            CFG_HOP_LENGTH:   hop_len_reg   = data[LEN_CFG_W-1:0];
            CFG_OUTPUT_GAIN:  gain_reg      = data[GAIN_W-1:0];
            default: ;
        endcase
    endtask

    // Present one item, hold it until the transfer, then predict its result.
    // Returns at the transfer edge with valid still high, so a following item
    // can go out back to back.
    task automatic send_item(
        input logic                   mode,
        input logic [COEF_IDX_W-1:0]  cidx,
        input logic [COEF_W-1:0]      cval,
        input logic [SAMPLE_BITS-1:0] smp,
        input logic                   typed,
        input logic [SAMPLE_BITS-1:0] want,
        input logic                   want_he
    );
        bit                     emit;
        logic [SAMPLE_BITS-1:0] y;
        logic                   he;
        t_hop_sample            due;
        if (idle_enable && $urandom_range(0, 99) < 20) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_mode       <= mode;
        i_coef_index <= cidx;
        i_coef_value <= cval;
        i_sample     <= smp;
        do @(posedge i_clk); while (o_in_stall);

        if (mode == MODE_COEF) coef_loaded[cidx] = 1'b1;
        overlap_add_step(mode, cidx, cval, smp, emit, y, he);
        if (emit) begin
            if (typed) begin
                due.out_sample = want;
                due.hop_end    = want_he;
            end else begin
                due.out_sample = y;
                due.hop_end    = he;
            end
            samples_due.push_back(due);
        end
    endtask

    // ------------------------------------------------------------------------
    // Directed table rows
    // ------------------------------------------------------------------------
    function automatic t_stim_row coef_row(input logic [COEF_IDX_W-1:0] idx,
                                           input logic [COEF_W-1:0]     val);
        t_stim_row row;
        row            = '0;
        row.kind       = ROW_ITEM;
        row.mode       = MODE_COEF;
        row.coef_index = idx;
        row.coef_value = val;
        return row;
    endfunction

    function automatic t_stim_row sample_row(input logic [SAMPLE_BITS-1:0] smp,
                                             input logic                   typed,
                                             input logic [SAMPLE_BITS-1:0] want,
                                             input logic                   want_he);
        t_stim_row row;
        row              = '0;
        row.kind         = ROW_ITEM;
        row.mode         = MODE_SAMPLE;
        row.sample       = smp;
        row.typed        = typed;
        row.want_sample  = want;
        row.want_hop_end = want_he;
        return row;
    endfunction

    function automatic t_stim_row cfg_row(input logic [CFG_IDX_W-1:0]  index,
                                          input logic [CFG_DATA_W-1:0] data);
        t_stim_row row;
        row           = '0;
        row.kind      = ROW_CFG;
        row.cfg_index = index;
        row.cfg_data  = data;
        return row;
    endfunction

    // ------------------------------------------------------------------------
    // Clock, limit and result-side stall
    // ------------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Ends a hung run; the slowest correct run is far shorter than this
    initial begin
        #5_000_000;
        $display("windowed_overlap_add test failed");
        $finish;
    end

    // Stall the result channel in bursts of random length while idling is on
    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (idle_enable && $urandom_range(0, 99) < 15) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 9)) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result checker: every result transfer pops the oldest expectation
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_hop_sample due;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (samples_due.size() == 0) begin
                report_mismatch("result with nothing due", $signed(o_out_sample), 0);
            end else begin
                due = samples_due.pop_front();
                if (o_out_sample !== due.out_sample) begin
                    report_mismatch("out_sample", $signed(o_out_sample),
                                    $signed(due.out_sample));
                end
                if (o_hop_end !== due.hop_end) begin
                    report_mismatch("hop_end", o_hop_end, due.hop_end);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin : stimulus
        t_stim_row             rows [$];
        int unsigned           eff, hop_raw, n, r, p;
        logic [LEN_CFG_W-1:0]  len_raw;
        logic [CFG_DATA_W-1:0] cfg_word;

        i_rst_n      = 1'b0;
        i_cfg_valid  = 1'b0;
        i_cfg_index  = '0;
        i_cfg_data   = '0;
        i_in_valid   = 1'b0;
        i_mode       = MODE_COEF;
        i_coef_index = '0;
        i_coef_value = '0;
        i_sample     = '0;

        for (int i = 0; i < MAX_FRAME; i++) begin
            window_coef[i] = '0;
            overlap_acc[i] = '0;
            coef_loaded[i] = 1'b0;
        end
        frame_len_reg = FRAME_LENGTH_RESET;
        hop_len_reg   = HOP_LENGTH_RESET;
        gain_reg      = OUTPUT_GAIN_RESET;
        frame_pos     = 0;
        ring_base     = 0;

        // Hold reset, then release it; the clearing pass afterwards shows as stall
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset framing (1024 / 512, unity gain): load the first taps and the top one
        rows.push_back(coef_row(10'd0, 16'd32768));      // 1.0
        rows.push_back(coef_row(10'd1, 16'hFFFF));       // largest coefficient
        rows.push_back(coef_row(10'd2, 16'd0));
        rows.push_back(coef_row(10'd3, 16'd32768));
        rows.push_back(coef_row(10'd1023, 16'd16384));   // highest index
        rows.push_back(sample_row(16'h7FFF, 1'b1, 16'h7FFF, 1'b0));
        rows.push_back(sample_row(16'h8000, 1'b1, 16'h8000, 1'b0)); // saturates low
        rows.push_back(sample_row(16'd12345, 1'b1, 16'd0, 1'b0));   // zero tap
        rows.push_back(sample_row(16'hFFFF, 1'b1, 16'hFFFF, 1'b0)); // -1 rounds to -1
        // Zero frame and zero hop both act as 1; full gain saturates the top end
        rows.push_back(cfg_row(CFG_FRAME_LENGTH, 16'd0));
        rows.push_back(cfg_row(CFG_HOP_LENGTH, 16'd0));
        rows.push_back(cfg_row(CFG_OUTPUT_GAIN, 16'hFFFF));
        rows.push_back(sample_row(16'h7FFF, 1'b1, 16'h7FFF, 1'b1));
        rows.push_back(sample_row(16'h8000, 1'b1, 16'h8000, 1'b1));
        rows.push_back(cfg_row(CFG_OUTPUT_GAIN, 16'd0));
        rows.push_back(sample_row(16'd1000, 1'b1, 16'd0, 1'b1));
        // Oversized frame and hop saturate to the store depth
        rows.push_back(cfg_row(CFG_FRAME_LENGTH, 16'd2047));
        rows.push_back(cfg_row(CFG_HOP_LENGTH, 16'd2047));
        rows.push_back(cfg_row(CFG_OUTPUT_GAIN, 16'd32768));
        rows.push_back(sample_row(16'd20000, 1'b0, '0, 1'b0));
        rows.push_back(sample_row(16'hB1E0, 1'b0, '0, 1'b0));
        rows.push_back(sample_row(16'h7FFF, 1'b0, '0, 1'b0));
        // Unused index changes nothing; frame write carries junk above bit 10
        rows.push_back(cfg_row(CFG_UNUSED, 16'hFFFF));
        rows.push_back(cfg_row(CFG_FRAME_LENGTH, 16'hF804));
        rows.push_back(cfg_row(CFG_HOP_LENGTH, 16'd2));
        // Mid-frame rewrap, a position past the hop that emits nothing, then overlap
        repeat (4) rows.push_back(sample_row(random_sample(), 1'b0, '0, 1'b0));

        foreach (rows[i]) begin
            if (rows[i].kind == ROW_CFG) begin
                write_register(rows[i].cfg_index, rows[i].cfg_data);
            end else begin
                send_item(rows[i].mode, rows[i].coef_index, rows[i].coef_value,
                          rows[i].sample, rows[i].typed, rows[i].want_sample,
                          rows[i].want_hop_end);
            end
        end

        // Random phases: new framing, fill the taps the traffic can reach, then traffic
        while (random_items < RANDOM_ITEMS) begin
            idle_enable = (random_items < QUIET_FROM) && ($urandom_range(0, 3) != 0);

            if ($urandom_range(0, 2) != 0) begin
                r = $urandom_range(0, 99);
                if (r < 4)       len_raw = '0;
                else if (r < 8)  len_raw = 11'd1024;
                else if (r < 11) len_raw = LEN_CFG_W'($urandom_range(1025, 2047));
                else             len_raw = LEN_CFG_W'($urandom_range(1, 24));
                cfg_word = CFG_DATA_W'($urandom);
                cfg_word[LEN_CFG_W-1:0] = len_raw;
                write_register(CFG_FRAME_LENGTH, cfg_word);
            end
            eff = effective_len(frame_len_reg);

            if ($urandom_range(0, 2) != 0) begin
                r = $urandom_range(0, 99);
                if (r < 8)       hop_raw = 0;
                else if (r < 16) hop_raw = $urandom_range(eff, 2047);
                else             hop_raw = $urandom_range(1, eff);
                cfg_word = CFG_DATA_W'($urandom);
                cfg_word[LEN_CFG_W-1:0] = LEN_CFG_W'(hop_raw);
                write_register(CFG_HOP_LENGTH, cfg_word);
            end

            if ($urandom_range(0, 2) != 0) begin
                r = $urandom_range(0, 99);
                if (r < 8)       cfg_word = '0;
                else if (r < 16) cfg_word = '1;
                else if (r < 24) cfg_word = 16'd32768;
                else             cfg_word = CFG_DATA_W'($urandom);
                write_register(CFG_OUTPUT_GAIN, cfg_word);
            end

            if ($urandom_range(0, 9) == 0) write_register(CFG_UNUSED, CFG_DATA_W'($urandom));

            n = $urandom_range(12, 40);

            // Load every tap that the next n samples can read
            p = frame_pos % eff;
            repeat (n) begin
                if (!coef_loaded[p]) begin
                    send_item(MODE_COEF, COEF_IDX_W'(p), random_coef(), random_sample(),
                              1'b0, '0, 1'b0);
                    random_items++;
                    if (random_items >= QUIET_FROM) idle_enable = 1'b0;
                end
                p = (p + 1 >= eff) ? 0 : p + 1;
            end

            repeat (n) begin
                if ($urandom_range(0, 99) < 8) begin
                    send_item(MODE_COEF, COEF_IDX_W'($urandom_range(0, MAX_FRAME - 1)),
                              random_coef(), random_sample(), 1'b0, '0, 1'b0);
                end else begin
                    send_item(MODE_SAMPLE, COEF_IDX_W'($urandom), COEF_W'($urandom),
                              random_sample(), 1'b0, '0, 1'b0);
                end
                random_items++;
                if (random_items >= QUIET_FROM) idle_enable = 1'b0;
            end
        end

        // Drop valid, drain the expectations, then watch for stray results
        i_in_valid <= 1'b0;
        while (samples_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (error_count == 0) begin
            $display("windowed_overlap_add test passed");
        end else begin
            $display("windowed_overlap_add test failed");
        end
        $finish;
    end

endmodule
